// ===== sv/p1tr_pkg.sv =====
// ----------------------------------------------------------------------------
// P1 telegram receiver package
// Shared constants, types and character/CRC helper functions.
// ----------------------------------------------------------------------------
package p1tr_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 1024;
  localparam int CHECKSUM_DIGITS     = 4;
  localparam int FRAME_LEN_W         = 11;

  // Queue between the classifier and the parser. Depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] CH_START = 8'h2F;  // '/'
  localparam logic [7:0] CH_END   = 8'h21;  // '!'

  localparam logic [2:0] EV_IGNORED  = 3'd0;
  localparam logic [2:0] EV_STARTED  = 3'd1;
  localparam logic [2:0] EV_STORED   = 3'd2;
  localparam logic [2:0] EV_ACCEPTED = 3'd3;
  localparam logic [2:0] EV_MISMATCH = 3'd4;
  localparam logic [2:0] EV_ABORTED  = 3'd5;

  typedef enum logic [2:0] {
    MODE_WAIT = 3'b001,
    MODE_READ = 3'b010,
    MODE_SUM  = 3'b100
  } mode_t;

  // One received byte with its character class, as queued for the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       allowed;
    logic       is_end;
    logic       is_start;
    logic       is_hex;
    logic [3:0] hex_val;
  } rx_class_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic char_allowed(input logic [7:0] c);
    logic ok;
    ok = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
         ((c >= 8'h41) && (c <= 8'h5A));
    // '.', ' ', backslash, CR, LF, '(', ')', '-', '*', ':', '_'
    ok = ok || (c == 8'h2E) || (c == 8'h20) || (c == 8'h5C) || (c == 8'h0D) ||
         (c == 8'h0A) || (c == 8'h28) || (c == 8'h29) || (c == 8'h2D) ||
         (c == 8'h2A) || (c == 8'h3A) || (c == 8'h5F);
    return ok;
  endfunction

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

// ===== sv/p1tr_front.sv =====
// ----------------------------------------------------------------------------
// P1 telegram receiver front end
// Accepts received bytes and tags each with its character class.
// ----------------------------------------------------------------------------
module p1tr_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                queue_full,
  output logic                push,
  output p1tr_pkg::rx_class_t push_data
);
  import p1tr_pkg::*;

  logic [4:0] hex;

  assign hex           = hex_decode(s_axis_tdata);
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  always_comb begin
    push_data.data     = s_axis_tdata;
    push_data.allowed  = char_allowed(s_axis_tdata);
    push_data.is_end   = (s_axis_tdata == CH_END);
    push_data.is_start = (s_axis_tdata == CH_START);
    push_data.is_hex   = hex[4];
    push_data.hex_val  = hex[3:0];
  end

endmodule

// ===== sv/p1tr_queue.sv =====
// ----------------------------------------------------------------------------
// P1 telegram receiver queue
// Small register queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module p1tr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  p1tr_pkg::rx_class_t push_data,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output p1tr_pkg::rx_class_t head
);
  import p1tr_pkg::*;

  rx_class_t              slots [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr;
  logic [QUEUE_IDX_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/p1tr_parser.sv =====
// ----------------------------------------------------------------------------
// P1 telegram receiver parser
// Frame state machine, running CRC, checksum capture and result register.
// ----------------------------------------------------------------------------
module p1tr_parser #(
  parameter int MAX_FRAME_BYTES = p1tr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                head_valid,
  input  p1tr_pkg::rx_class_t head,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,
  output logic [3:0]          m_axis_tuser
);
  import p1tr_pkg::*;

  localparam int LenW = $clog2(MAX_FRAME_BYTES + 1);

  logic        checksum_enable;
  mode_t       mode, mode_next, mode_eff;
  logic [15:0] crc, crc_next, crc_upd;
  logic [15:0] rx_sum, rx_sum_next, rx_shift;
  logic [2:0]  digits, digits_next, digits_inc;
  logic [LenW-1:0] len, len_next, len_inc;

  logic        ovf;
  logic [2:0]  ev;
  logic [15:0] crc_out;
  logic [FRAME_LEN_W-1:0] len_out;

  logic [2:0]  out_ev;
  logic        out_ovf;
  logic [15:0] out_crc;
  logic [FRAME_LEN_W-1:0] out_len;

  assign pop = head_valid && (!m_axis_tvalid || m_axis_tready);

  assign crc_upd    = crc_add(crc, head.data);
  assign len_inc    = len + 1'b1;
  assign rx_shift   = {rx_sum[11:0], head.hex_val};
  assign digits_inc = digits + 1'b1;

  always_comb begin
    ovf         = (mode != MODE_WAIT) && (len >= LenW'(MAX_FRAME_BYTES - 2));
    mode_eff    = ovf ? MODE_WAIT : mode;
    mode_next   = mode;
    crc_next    = crc;
    rx_sum_next = rx_sum;
    digits_next = digits;
    len_next    = len;
    ev          = EV_IGNORED;
    crc_out     = '0;
    len_out     = '0;

    // The length limit drops the open frame before the byte is looked at.
    if (ovf) begin
      mode_next   = MODE_WAIT;
      len_next    = '0;
      digits_next = '0;
    end

    unique case (mode_eff)
      MODE_WAIT: begin
      end
      MODE_READ: begin
        if (head.allowed) begin
          crc_next = crc_upd;
          len_next = len_inc;
          ev       = EV_STORED;
          len_out  = FRAME_LEN_W'(len_inc);
        end else if (head.is_end) begin
          crc_next = crc_upd;
          len_out  = FRAME_LEN_W'(len_inc);
          if (checksum_enable) begin
            mode_next   = MODE_SUM;
            len_next    = len_inc;
            digits_next = '0;
            rx_sum_next = '0;
            ev          = EV_STORED;
          end else begin
            mode_next   = MODE_WAIT;
            len_next    = '0;
            digits_next = '0;
            ev          = EV_ACCEPTED;
            crc_out     = crc_upd;
          end
        end else if (head.is_start) begin
          // Stray start mark: drop the frame, the restart is handled below.
          mode_next   = MODE_WAIT;
          len_next    = '0;
          digits_next = '0;
        end else begin
          mode_next   = MODE_WAIT;
          len_next    = '0;
          digits_next = '0;
          ev          = EV_ABORTED;
          len_out     = FRAME_LEN_W'(len);
        end
      end
      MODE_SUM: begin
        if (head.is_hex) begin
          rx_sum_next = rx_shift;
          len_out     = FRAME_LEN_W'(len_inc);
          if (digits_inc >= 3'(CHECKSUM_DIGITS)) begin
            mode_next   = MODE_WAIT;
            len_next    = '0;
            digits_next = '0;
            crc_out     = crc;
            ev          = (rx_shift == crc) ? EV_ACCEPTED : EV_MISMATCH;
          end else begin
            digits_next = digits_inc;
            len_next    = len_inc;
            ev          = EV_STORED;
          end
        end else begin
          mode_next   = MODE_WAIT;
          len_next    = '0;
          digits_next = '0;
          ev          = EV_ABORTED;
          len_out     = FRAME_LEN_W'(len);
        end
      end
      default: begin
        mode_next   = MODE_WAIT;
        len_next    = '0;
        digits_next = '0;
      end
    endcase

    if ((mode_next == MODE_WAIT) && (ev == EV_IGNORED) && head.is_start) begin
      mode_next   = MODE_READ;
      crc_next    = crc_add(16'h0000, head.data);
      rx_sum_next = '0;
      digits_next = '0;
      len_next    = LenW'(1);
      ev          = EV_STARTED;
      len_out     = FRAME_LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_enable <= 1'b1;
    end else if (cfg_we) begin
      checksum_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_WAIT;
      crc           <= '0;
      rx_sum        <= '0;
      digits        <= '0;
      len           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        mode   <= mode_next;
        crc    <= crc_next;
        rx_sum <= rx_sum_next;
        digits <= digits_next;
        len    <= len_next;
      end
      if (pop) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ev  <= ev;
      out_ovf <= ovf;
      out_crc <= crc_out;
      out_len <= len_out;
    end
  end

  assign m_axis_tdata = {(32 - 16 - FRAME_LEN_W)'(0), out_len, out_crc};
  assign m_axis_tuser = {out_ovf, out_ev};

endmodule

// ===== sv/p1_telegram_receiver_crc16_top.sv =====
// ----------------------------------------------------------------------------
// P1 telegram receiver with CRC-16 check
// Parses smart-meter telegram bytes and reports one event item per byte.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                  Contents
// s_axis    in   tvalid tready tdata[7:0] [7:0] rx_byte
// m_axis    out  tvalid tready tdata[31:0] [15:0] frame_crc, [26:16] frame_length
//                tuser[3:0]               [2:0] event_code, [3] overflow_reset
// cfg       in   we wdata                 checksum_enable
//
// One item per cycle sustained while m_axis_tready is high; an input byte is held
// in the queue, then its result is captured in the parser result register.
// The parser folds a whole byte into the CRC per cycle, which sets the rate.
// Reset is synchronous; it empties the queue and sets checksum_enable to 1.
// A stall on m_axis fills the four-entry queue before s_axis_tready drops.
// ----------------------------------------------------------------------------
module p1_telegram_receiver_crc16_top #(
  parameter int MAX_FRAME_BYTES = p1tr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] frame_crc, [26:16] frame_length
  output logic [3:0]  m_axis_tuser,   // [2:0] event_code, [3] overflow_reset
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import p1tr_pkg::*;

  logic      push, pop, queue_full, head_valid;
  rx_class_t push_data, head;

  p1tr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .queue_full    (queue_full),
    .push          (push),
    .push_data     (push_data)
  );

  p1tr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (head_valid),
    .head      (head)
  );

  p1tr_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== sv/p1tr_checker.sv =====
// ----------------------------------------------------------------------------
// P1 telegram receiver checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module p1tr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  import p1tr_pkg::*;

  // A held result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[2:0] <= EV_ABORTED)
    else $error("event code out of range");

  // The CRC is only reported when a frame completes.
  a_crc_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[2:0] != EV_ACCEPTED) &&
    (m_axis_tuser[2:0] != EV_MISMATCH) |-> m_axis_tdata[15:0] == 16'h0000)
    else $error("frame CRC reported outside frame end");

  a_start_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[2:0] == EV_STARTED) |->
    m_axis_tdata[16+FRAME_LEN_W-1:16] == FRAME_LEN_W'(1))
    else $error("frame start with wrong length");

endmodule

bind p1_telegram_receiver_crc16_top p1tr_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/telegram_event_checker.sv =====
// ----------------------------------------------------------------------------
// Telegram event checker
// Watches the byte, event and register ports of the P1 telegram receiver. It
// keeps its own model of the frame parser, queues one expected event per
// accepted byte, and compares every delivered event field by field.
// ----------------------------------------------------------------------------
module telegram_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_valid,
  input  logic        s_ready,
  input  logic [7:0]  s_data,
  input  logic        m_valid,
  input  logic        m_ready,
  input  logic [31:0] m_data,
  input  logic [3:0]  m_user,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output int          pending,
  output int          fails
);
  import p1tr_pkg::*;

  localparam logic [15:0] ARC_POLY = 16'hA001;

  typedef struct packed {
    logic [2:0]  event_code;
    logic        overflow_reset;
    logic [15:0] frame_crc;
    logic [10:0] frame_length;
  } telegram_event_t;

  telegram_event_t expected_events[$];
  int              events_checked;

  // Parser state as the block should hold it.
  mode_t       mode;
  logic [15:0] crc_acc;
  logic [15:0] sum_acc;
  logic [2:0]  digits;
  logic [10:0] len_acc;
  logic        sum_on;

  // Bitwise form of the reflected CRC-16: each data bit meets the low bit.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = {1'b0, c[15:1]} ^ (fb ? ARC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic bit telegram_char(logic [7:0] c);
    case (c)
      ".", " ", "\\", 8'h0D, 8'h0A, "(", ")", "-", "*", ":", "_": return 1'b1;
      default: return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                      (c >= "A" && c <= "Z");
    endcase
  endfunction

  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void drop_frame();
    mode = MODE_WAIT;
    len_acc = '0;
    digits = '0;
  endfunction

  function automatic telegram_event_t parse_telegram_byte(logic [7:0] c);
    telegram_event_t r;
    int              h;
    r = '0;
    r.event_code = EV_IGNORED;
    // The length limit is applied before the byte itself is looked at.
    if (mode != MODE_WAIT && int'(len_acc) + 2 >= MAX_FRAME_BYTES_DEF) begin
      r.overflow_reset = 1'b1;
      drop_frame();
    end
    case (mode)
      MODE_READ: begin
        if (telegram_char(c)) begin
          crc_acc = crc16_byte(crc_acc, c);
          len_acc = len_acc + 11'd1;
          r.event_code = EV_STORED;
          r.frame_length = len_acc;
        end else if (c == CH_END) begin
          crc_acc = crc16_byte(crc_acc, c);
          len_acc = len_acc + 11'd1;
          r.frame_length = len_acc;
          if (sum_on) begin
            mode = MODE_SUM;
            digits = '0;
            sum_acc = '0;
            r.event_code = EV_STORED;
          end else begin
            r.event_code = EV_ACCEPTED;
            r.frame_crc = crc_acc;
            drop_frame();
          end
        end else if (c == CH_START) begin
          drop_frame();
        end else begin
          r.event_code = EV_ABORTED;
          r.frame_length = len_acc;
          drop_frame();
        end
      end
      MODE_SUM: begin
        h = hex_digit_value(c);
        if (h >= 0) begin
          sum_acc = {sum_acc[11:0], h[3:0]};
          digits = digits + 3'd1;
          len_acc = len_acc + 11'd1;
          r.frame_length = len_acc;
          if (int'(digits) >= CHECKSUM_DIGITS) begin
            r.frame_crc = crc_acc;
            r.event_code = (sum_acc == crc_acc) ? EV_ACCEPTED : EV_MISMATCH;
            drop_frame();
          end else begin
            r.event_code = EV_STORED;
          end
        end else begin
          r.event_code = EV_ABORTED;
          r.frame_length = len_acc;
          drop_frame();
        end
      end
      default: ;
    endcase
    // A start mark opens a frame unless it was already consumed as an abort.
    if (mode == MODE_WAIT && r.event_code == EV_IGNORED && c == CH_START) begin
      crc_acc = crc16_byte(16'h0000, c);
      sum_acc = '0;
      digits = '0;
      len_acc = 11'd1;
      mode = MODE_READ;
      r.event_code = EV_STARTED;
      r.frame_length = 11'd1;
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t event %0d: %s", $time, events_checked, msg);
    fails++;
  endtask

  always @(posedge clk) begin
    telegram_event_t want;
    if (rst) begin
      mode = MODE_WAIT;
      crc_acc = '0;
      sum_acc = '0;
      digits = '0;
      len_acc = '0;
      sum_on = 1'b1;
      expected_events.delete();
      events_checked = 0;
      fails = 0;
    end else begin
      if (m_valid && m_ready) begin
        if (expected_events.size() == 0) begin
          report_error("event item delivered with none outstanding");
        end else begin
          want = expected_events.pop_front();
          if (m_user[2:0] !== want.event_code)
            report_error($sformatf("event_code %0d, expected %0d",
                                   m_user[2:0], want.event_code));
          if (m_user[3] !== want.overflow_reset)
            report_error($sformatf("overflow_reset %0b, expected %0b",
                                   m_user[3], want.overflow_reset));
          if (m_data[15:0] !== want.frame_crc)
            report_error($sformatf("frame_crc %04h, expected %04h",
                                   m_data[15:0], want.frame_crc));
          if (m_data[26:16] !== want.frame_length)
            report_error($sformatf("frame_length %0d, expected %0d",
                                   m_data[26:16], want.frame_length));
          if (m_data[31:27] !== 5'd0)
            report_error($sformatf("tdata padding %b, expected zeros", m_data[31:27]));
        end
        events_checked++;
      end
      if (cfg_we) sum_on = cfg_wdata;
      if (s_valid && s_ready) expected_events.push_back(parse_telegram_byte(s_data));
    end
    pending = expected_events.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// P1 telegram receiver testbench
// Feeds telegram bytes (directed cases, random frames with noise and broken
// sequences, and a frame that hits the length limit) with random idling on both
// streams, and lets the event checker judge every result item.
// ----------------------------------------------------------------------------
module tb_top;
  import p1tr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire [31:0]  m_data;
  wire [3:0]   m_user;
  int          pending;
  int          fails;

  bit          burst = 1'b0;
  bit          sum_on = 1'b1;
  logic [15:0] tx_crc = 16'h0000;
  int          frame_bytes = 0;
  int          delivered = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  p1_telegram_receiver_crc16_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  telegram_event_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .m_user    (m_user),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .fails     (fails)
  );

  // Sender side CRC, needed to build checksum characters that match.
  function automatic logic [15:0] tx_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return "0" + {4'h0, n};
    return (upper ? "A" : "a") + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] pick_body();
    int k;
    k = $urandom_range(0, 72);
    if (k < 10) return "0" + k[7:0];
    if (k < 36) return "a" + k[7:0] - 8'd10;
    if (k < 62) return "A" + k[7:0] - 8'd36;
    case (k)
      62: return ".";
      63: return " ";
      64: return "\\";
      65: return 8'h0D;
      66: return 8'h0A;
      67: return "(";
      68: return ")";
      69: return "-";
      70: return "*";
      71: return ":";
      default: return "_";
    endcase
  endfunction

  // Bytes outside the telegram character set, excluding both marks.
  function automatic logic [7:0] pick_invalid();
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0: v = 8'($urandom_range(8'h80, 8'hFF));
      1: v = 8'($urandom_range(8'h00, 8'h09));
      2: v = 8'($urandom_range(8'h3B, 8'h40));
      3: v = 8'($urandom_range(8'h7B, 8'h7F));
      4: v = 8'($urandom_range(8'h22, 8'h27));
      default: v = 8'($urandom_range(8'h0E, 8'h1F));
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_nonhex();
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0: v = CH_START;
      1: v = CH_END;
      2: v = 8'($urandom_range("g", "z"));
      3: v = 8'($urandom_range("G", "Z"));
      4: v = pick_invalid();
      default: v = " ";
    endcase
    return v;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= b;
    do @(posedge clk); while (!s_ready);
    frame_bytes++;
  endtask

  task automatic send_stored(input logic [7:0] b);
    send_byte(b);
    tx_crc = tx_crc_step(tx_crc, b);
  endtask

  task automatic open_frame();
    tx_crc = 16'h0000;
    send_stored(CH_START);
  endtask

  task automatic send_checksum(input logic [15:0] crc, input bit corrupt);
    logic [15:0] v;
    v = crc;
    if (corrupt) v = v ^ (16'h0001 << $urandom_range(0, 15));
    for (int i = 3; i >= 0; i--) send_byte(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
  endtask

  // Noise between frames; these bytes are not counted as stimulus.
  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    frame_bytes -= n;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_checksum(input bit v);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sum_on = v;
  endtask

  task automatic send_frame();
    int kind;
    int n;
    burst = ($urandom_range(0, 6) == 0);
    if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 3));
    kind = $urandom_range(0, 99);
    n = $urandom_range(0, 24);
    open_frame();
    if (kind >= 75 && kind < 83) begin
      // Stray start mark partway through restarts the frame.
      repeat ($urandom_range(0, 6)) send_stored(pick_body());
      open_frame();
    end
    if (kind >= 65 && kind < 75) begin
      repeat ($urandom_range(0, n)) send_stored(pick_body());
      send_byte(pick_invalid());
    end else if (kind >= 91) begin
      // Left open; the next start mark restarts it.
      repeat (n) send_stored(pick_body());
    end else begin
      repeat (n) send_stored(pick_body());
      send_stored(CH_END);
      if (sum_on) begin
        if (kind >= 83) begin
          repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15)),
                                                           1'($urandom_range(0, 1))));
          send_byte(pick_nonhex());
        end else begin
          send_checksum(tx_crc, $urandom_range(0, 9) == 0);
        end
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold that backs up the input.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 6);
      if (delivered == 400) stall = 200;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!(m_valid && m_ready));
      delivered++;
    end
  end

  initial begin
    #4000000;
    $display("p1_telegram_receiver_crc16_top regression: fail");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, checksum checking on from reset.
    send_byte(8'h00);
    send_byte(8'hFF);
    open_frame();
    open_frame();
    send_stored("a");
    send_byte("#");
    open_frame();
    send_stored(CH_END);
    send_checksum(tx_crc, 1'b0);
    open_frame();
    send_stored(CH_END);
    send_byte(CH_START);
    open_frame();
    send_stored(CH_END);
    send_byte("G");
    open_frame();
    send_stored(CH_END);
    send_checksum(tx_crc, 1'b1);
    set_checksum(1'b0);
    open_frame();
    send_stored(CH_END);

    // Random frames; register writes land between phases, sometimes mid-frame.
    frame_bytes = 0;
    for (int phase = 0; phase < 4; phase++) begin
      set_checksum(phase == 1 ? 1'b0 : (phase == 2 ? bit'($urandom_range(0, 1)) : 1'b1));
      while (frame_bytes < (phase + 1) * 40) send_frame();
    end

    // Length limit while reading: the start mark is handled after the drop.
    burst = 1'b0;
    set_checksum(1'b1);
    open_frame();
    repeat (MAX_FRAME_BYTES_DEF - 3) send_stored(pick_body());
    open_frame();
    send_stored(CH_END);
    send_checksum(tx_crc, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fails == 0) begin
      $display("p1_telegram_receiver_crc16_top regression: pass");
    end else begin
      $display("p1_telegram_receiver_crc16_top regression: fail");
    end
    $finish;
  end

endmodule
